/* hw/rtl/cob_pkg.sv */
package cob_pkg;

	localparam logic [7:0]  FULL        = 8'd255;
	localparam logic [15:0] ROUND_ALPHA = 16'h0080;
	localparam int          FRAC_BITS   = 16;
	localparam int          PROD_W      = 27;
	localparam logic signed [PROD_W-1:0] ROUND_CHAN = 27'sh0008000;

	// The blend factor never exceeds 65536, so 17 quotient bits suffice;
	// the divider produces DIV_STEP bits per stage.
	localparam int Q_BITS     = 18;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = Q_BITS / DIV_STEP;

	localparam logic [1:0] CFG_RED   = 2'd0;
	localparam logic [1:0] CFG_GREEN = 2'd1;
	localparam logic [1:0] CFG_BLUE  = 2'd2;

	typedef struct packed {
		logic [7:0] coverage;
		logic [7:0] dest_red;
		logic [7:0] dest_green;
		logic [7:0] dest_blue;
		logic [7:0] dst_alpha;
	} in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} out_t;

	typedef struct packed {
		logic              bypass;
		logic [7:0]        coverage;
		logic [7:0]        alpha;
		logic [7:0]        dst_red;
		logic [7:0]        dst_green;
		logic [7:0]        dst_blue;
		logic [7:0]        dvs;
		logic [7:0]        rem;
		logic [Q_BITS-1:0] num;
		logic [Q_BITS-1:0] quo;
	} div_t;

endpackage

/* hw/rtl/cob_div_stage.sv */
module cob_div_stage
	import cob_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  div_t d_in,
	output logic v_out,
	output div_t d_out
);

	logic v_q;
	div_t d_q;
	div_t nxt;
	logic [8:0] r9;

	always_comb begin
		nxt = d_in;
		r9 = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			r9 = {nxt.rem, nxt.num[Q_BITS-1]};
			nxt.num = {nxt.num[Q_BITS-2:0], 1'b0};
			if (r9 >= {1'b0, nxt.dvs}) begin
				nxt.rem = 8'(r9 - {1'b0, nxt.dvs});
				nxt.quo = {nxt.quo[Q_BITS-2:0], 1'b1};
			end else begin
				nxt.rem = r9[7:0];
				nxt.quo = {nxt.quo[Q_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign v_out = v_q;
	assign d_out = d_q;

endmodule

/* hw/rtl/coverage_over_rgba_blend.sv */
// An accepted input transaction passes stages 1 and 2, the divider stages and stages 9 and 10.
// Throughput: one pixel per cycle while out_stall is low; the restoring divider retires
// three quotient bits per stage over six stages, and every stage holds its own pixel.
// Stall: a stage loads only when it is empty or its successor moves.
// Reset clears all valid bits and the three foreground color registers to zero.
module coverage_over_rgba_blend
	import cob_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] fore_red_q;
	logic [7:0] fore_green_q;
	logic [7:0] fore_blue_q;

	logic        v_s1;
	in_t         in_s1;
	logic [15:0] prod_s1;

	logic v_s2;
	div_t d_s2;

	logic [DIV_STAGES-1:0] v_dv;
	div_t                  d_dv [DIV_STAGES];
	logic [DIV_STAGES:0]   en_dv;

	logic                     v_s9;
	logic                     bypass_s9;
	logic [7:0]               cov_s9;
	logic [7:0]               alpha_s9;
	logic [2:0][7:0]          dst_s9;
	logic signed [PROD_W-1:0] prod_s9 [3];

	logic v_s10;
	out_t out_s10;

	logic en_s1;
	logic en_s2;
	logic en_s9;
	logic en_s10;

	logic [15:0]     t_c;
	logic [16:0]     sum_c;
	logic [7:0]      a_c;
	logic [7:0]      dvs_c;
	div_t            d_c;
	logic [2:0][7:0] fg_c;
	logic [2:0][7:0] dst_c;
	logic [2:0][7:0] res_c;

	function automatic logic [7:0] blend_fin(input logic signed [PROD_W-1:0] p,
	                                         input logic [7:0] dst);
		logic signed [PROD_W-1:0] v;
		logic signed [10:0]       r;
		v = p + ROUND_CHAN;
		r = $signed({3'b000, dst}) + $signed(v[PROD_W-1:FRAC_BITS]);
		if (r < 0) begin
			return 8'd0;
		end else if (r > 11'sd255) begin
			return FULL;
		end else begin
			return r[7:0];
		end
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_red_q <= 8'd0;
			fore_green_q <= 8'd0;
			fore_blue_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RED: fore_red_q <= cfg_data;
				CFG_GREEN: fore_green_q <= cfg_data;
				CFG_BLUE: fore_blue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en_s10 = !v_s10 || !out_stall;
	assign en_s9 = !v_s9 || en_s10;
	assign en_dv[DIV_STAGES] = en_s9;
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_en
		assign en_dv[k] = !v_dv[k] || en_dv[k+1];
	end
	assign en_s2 = !v_s2 || en_dv[0];
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Stage 1: product of the two inverse alphas.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			in_s1 <= in_data;
			prod_s1 <= (16'(FULL) - 16'(in_data.coverage)) *
				(16'(FULL) - 16'(in_data.dst_alpha));
		end
	end

	// Stage 2: combined alpha and the dividend for the blend factor.
	always_comb begin
		t_c = prod_s1 + ROUND_ALPHA;
		sum_c = {1'b0, t_c} + {9'd0, t_c[15:8]};
		a_c = 8'(FULL - sum_c[16:8]);
		dvs_c = (a_c == 8'd0) ? 8'd1 : a_c;
		d_c.bypass = (in_s1.dst_alpha == 8'd0);
		d_c.coverage = in_s1.coverage;
		d_c.alpha = a_c;
		d_c.dst_red = in_s1.dest_red;
		d_c.dst_green = in_s1.dest_green;
		d_c.dst_blue = in_s1.dest_blue;
		d_c.dvs = dvs_c;
		d_c.rem = {2'b00, in_s1.coverage[7:2]};
		d_c.num = {in_s1.coverage[1:0], 9'd0, dvs_c[7:1]};
		d_c.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			d_s2 <= d_c;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		if (k == 0) begin : g_first
			cob_div_stage u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (en_dv[k]),
				.v_in  (v_s2),
				.d_in  (d_s2),
				.v_out (v_dv[k]),
				.d_out (d_dv[k])
			);
		end else begin : g_rest
			cob_div_stage u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (en_dv[k]),
				.v_in  (v_dv[k-1]),
				.d_in  (d_dv[k-1]),
				.v_out (v_dv[k]),
				.d_out (d_dv[k])
			);
		end
	end

	// Stage 9: signed channel differences scaled by the blend factor.
	assign fg_c = {fore_blue_q, fore_green_q, fore_red_q};
	assign dst_c = {d_dv[DIV_STAGES-1].dst_blue, d_dv[DIV_STAGES-1].dst_green,
		d_dv[DIV_STAGES-1].dst_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en_s9) begin
			v_s9 <= v_dv[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			bypass_s9 <= d_dv[DIV_STAGES-1].bypass;
			cov_s9 <= d_dv[DIV_STAGES-1].coverage;
			alpha_s9 <= d_dv[DIV_STAGES-1].alpha;
			dst_s9 <= dst_c;
			for (int i = 0; i < 3; i++) begin
				prod_s9[i] <= $signed(PROD_W'($signed({1'b0, fg_c[i]}) -
					$signed({1'b0, dst_c[i]}))) *
					$signed({{(PROD_W-Q_BITS){1'b0}}, d_dv[DIV_STAGES-1].quo});
			end
		end
	end

	// Stage 10: rounding, saturation, the bypass select and the output register.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_c[i] = blend_fin(prod_s9[i], dst_s9[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en_s10) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			if (bypass_s9) begin
				out_s10 <= {fore_red_q, fore_green_q, fore_blue_q, cov_s9};
			end else begin
				out_s10 <= {res_c[0], res_c[1], res_c[2], alpha_s9};
			end
		end
	end

	assign out_valid = v_s10;
	assign out_data = out_s10;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled while the first stage is empty");

	a_alpha_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !d_s2.bypass) |-> (d_s2.alpha != 8'd0 && d_s2.alpha >= d_s2.coverage))
		else $error("combined alpha below coverage");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv[DIV_STAGES-1] && !d_dv[DIV_STAGES-1].bypass) |->
		(d_dv[DIV_STAGES-1].quo <= 18'd65536))
		else $error("blend factor out of range");

	a_output_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && !v_s10) |=> v_s10)
		else $error("pending pixel did not reach the output register");
`endif

endmodule

/* test/coverage_over_rgba_blend_checker.sv */
`timescale 1ns / 100ps

module coverage_over_rgba_blend_checker
	import cob_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  in_t        in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_t       out_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         mismatches,
	output int         pixels_in_flight
);

	logic [7:0] fore_red_q;
	logic [7:0] fore_green_q;
	logic [7:0] fore_blue_q;
	out_t       expected_pixels[$];
	out_t       oldest_pixel;
	int         error_total;

	function automatic logic [7:0] mix_channel(logic [7:0] fore, logic [7:0] dest, int factor);
		int step;
		int blended;
		step = ((int'(fore) - int'(dest)) * factor + 32768) >>> 16;
		blended = int'(dest) + step;
		if (blended < 0) begin
			blended = 0;
		end
		if (blended > 255) begin
			blended = 255;
		end
		return blended[7:0];
	endfunction

	function automatic out_t blend_pixel(in_t px);
		out_t result;
		int   inv_product;
		int   alpha;
		int   divisor;
		int   factor;
		if (px.dst_alpha == 8'd0) begin
			result.out_red   = fore_red_q;
			result.out_green = fore_green_q;
			result.out_blue  = fore_blue_q;
			result.out_alpha = px.coverage;
			return result;
		end
		inv_product = (255 - int'(px.coverage)) * (255 - int'(px.dst_alpha)) + 128;
		alpha = 255 - ((inv_product + (inv_product >> 8)) >> 8);
		divisor = (alpha == 0) ? 1 : alpha;
		factor = ((int'(px.coverage) << 16) + (divisor >> 1)) / divisor;
		result.out_red   = mix_channel(fore_red_q, px.dest_red, factor);
		result.out_green = mix_channel(fore_green_q, px.dest_green, factor);
		result.out_blue  = mix_channel(fore_blue_q, px.dest_blue, factor);
		result.out_alpha = alpha[7:0];
		return result;
	endfunction

	task automatic check_channel(string name, logic [7:0] expected, logic [7:0] actual);
		if (actual !== expected) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
			error_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_red_q = '0;
			fore_green_q = '0;
			fore_blue_q = '0;
			expected_pixels.delete();
			error_total = 0;
			mismatches <= 0;
			pixels_in_flight <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected output transaction, expected none, got %h",
						$time, out_data);
					error_total++;
				end else begin
					oldest_pixel = expected_pixels.pop_front();
					check_channel("out_red", oldest_pixel.out_red, out_data.out_red);
					check_channel("out_green", oldest_pixel.out_green, out_data.out_green);
					check_channel("out_blue", oldest_pixel.out_blue, out_data.out_blue);
					check_channel("out_alpha", oldest_pixel.out_alpha, out_data.out_alpha);
				end
			end
			if (in_valid && !in_stall) begin
				expected_pixels.push_back(blend_pixel(in_data));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RED: begin
						fore_red_q = cfg_data;
					end
					CFG_GREEN: begin
						fore_green_q = cfg_data;
					end
					CFG_BLUE: begin
						fore_blue_q = cfg_data;
					end
					default: begin
					end
				endcase
			end
			mismatches <= error_total;
			pixels_in_flight <= expected_pixels.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import cob_pkg::*;

	localparam int         CYCLE_LIMIT      = 200000;
	localparam int         RANDOM_PHASES    = 9;
	localparam int         PIXELS_PER_PHASE = 100;
	localparam int         HOLD_CYCLES      = 300;
	localparam int         SETTLE_CYCLES    = 12;
	localparam logic [1:0] CFG_UNUSED       = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_t        in_data;
	logic       out_valid;
	logic       out_stall;
	out_t       out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	int         mismatches;
	int         pixels_in_flight;
	int         cycle_count = 0;
	bit         sender_quiet;

	coverage_over_rgba_blend u_top (.*);

	coverage_over_rgba_blend_checker u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("coverage_over_rgba_blend test failed");
			$finish;
		end
	end

	function automatic in_t make_pixel(logic [7:0] cov, logic [7:0] red, logic [7:0] green,
		logic [7:0] blue, logic [7:0] alpha);
		in_t px;
		px.coverage = cov;
		px.dest_red = red;
		px.dest_green = green;
		px.dest_blue = blue;
		px.dst_alpha = alpha;
		return px;
	endfunction

	function automatic logic [7:0] pick_byte();
		int choice;
		choice = $urandom_range(0, 7);
		if (choice == 0) begin
			return 8'd0;
		end else if (choice == 1) begin
			return 8'd255;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic write_register(logic [1:0] index, logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_foreground(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		write_register(CFG_RED, red);
		write_register(CFG_GREEN, green);
		write_register(CFG_BLUE, blue);
	endtask

	task automatic send_pixel(in_t px);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_in_flight != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int accepted;
		int hold;
		out_stall = 1'b0;
		accepted = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (accepted == 250 || accepted == 560) begin
				hold = HOLD_CYCLES;
			end else if ((accepted / 80) % 3 == 1) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 18);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			accepted++;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RED;
		cfg_data = '0;
		sender_quiet = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The foreground color comes out of reset as black.
		send_pixel(make_pixel(8'd128, 8'd50, 8'd60, 8'd70, 8'd0));
		send_pixel(make_pixel(8'd200, 8'd10, 8'd20, 8'd30, 8'd100));
		drain();

		set_foreground(8'd200, 8'd30, 8'd90);
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0));
		send_pixel(make_pixel(8'd77, 8'd1, 8'd2, 8'd3, 8'd0));
		send_pixel(make_pixel(8'd0, 8'd10, 8'd200, 8'd255, 8'd255));
		send_pixel(make_pixel(8'd0, 8'd10, 8'd200, 8'd255, 8'd1));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd255));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd1));
		send_pixel(make_pixel(8'd1, 8'd255, 8'd0, 8'd255, 8'd1));
		send_pixel(make_pixel(8'd1, 8'd0, 8'd255, 8'd0, 8'd255));
		send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 8'd128, 8'd128));
		send_pixel(make_pixel(8'd254, 8'd255, 8'd255, 8'd255, 8'd254));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd128));
		send_pixel(make_pixel(8'd12, 8'd34, 8'd56, 8'd78, 8'd90));
		send_pixel(make_pixel(8'd200, 8'd255, 8'd0, 8'd0, 8'd17));
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					set_foreground(8'd0, 8'd0, 8'd0);
				end
				1: begin
					set_foreground(8'd255, 8'd255, 8'd255);
				end
				2: begin
					set_foreground(8'd255, 8'd0, 8'd255);
				end
				default: begin
					set_foreground(pick_byte(), pick_byte(), pick_byte());
				end
			endcase
			// Writes to the unused index must leave the color alone.
			write_register(CFG_UNUSED, 8'($urandom_range(0, 255)));
			sender_quiet = (phase == 3 || phase == 6);
			repeat (PIXELS_PER_PHASE) begin
				send_pixel(make_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
					pick_byte()));
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("coverage_over_rgba_blend test passed");
		end else begin
			$display("coverage_over_rgba_blend test failed");
		end
		$finish;
	end

endmodule

/* coverage_over_rgba_blend.f */
hw/rtl/cob_pkg.sv
hw/rtl/cob_div_stage.sv
hw/rtl/coverage_over_rgba_blend.sv
test/coverage_over_rgba_blend_checker.sv
test/testbench.sv
